// ===== rtl/fpu_stack_register_cache_assert.svh =====
// Assertion macros for the stack register cache module.
`ifndef FPU_STACK_REGISTER_CACHE_ASSERT_SVH
`define FPU_STACK_REGISTER_CACHE_ASSERT_SVH

// Clocked assertion, held off while reset is applied.
`define FSRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked implication with the same reset handling.
`define FSRC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fpusrc_pkg.sv =====
// Types and constants of the x87 stack register cache.
package fpusrc_pkg;

	localparam int unsigned MAX_RES = 8;

	typedef enum logic [2:0] {
		CMD_RESET   = 3'd0,
		CMD_PUSH    = 3'd1,
		CMD_POP     = 3'd2,
		CMD_GET     = 3'd3,
		CMD_REFRESH = 3'd4,
		CMD_PURGE   = 3'd5,
		CMD_SYNC    = 3'd6
	} cmd_e;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_STORE = 2'd2
	} action_e;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_PUSH,
		OP_POP,
		OP_GET,
		OP_FREE
	} cell_op_e;

	typedef enum logic {
		ST_IDLE,
		ST_PURGE
	} state_e;

	localparam logic [3:0]        DEPTH_MAX     = 4'd15;
	localparam logic signed [5:0] PEND_MAX      = 6'sd31;
	localparam logic signed [5:0] PEND_MIN      = 6'b100000;
	localparam logic [2:0]        PURGE_LAST_IX = 3'(MAX_RES - 1);

	// Broadcast to every cell.
	typedef struct packed {
		cell_op_e   op;
		logic       alloc;
	} cell_ctl_t;

	// Priority chain passed from cell to cell.
	typedef struct packed {
		logic free_seen;
		logic hit_seen;
		logic valid_seen;
		logic valid_two;
	} chain_t;

	typedef struct packed {
		logic       first_free;
		logic       first_hit;
		logic       first_valid;
		logic [3:0] depth;
	} cell_stat_t;

	// Result word, slot in the lowest bits.
	typedef struct packed {
		logic [4:0]        pad;
		logic [2:0]        new_top;
		logic signed [5:0] stack_delta;
		logic [2:0]        phys_index;
		action_e           action;
		logic              full_res;
		logic              hit;
		logic [2:0]        slot;
	} res_t;

endpackage

// ===== rtl/fpu_stack_register_cache.sv =====
// x87 stack register cache: maps stack positions onto SLOTS host register slots,
// one cell per slot, with the first free, first matching and first valid slot
// found by a priority chain running through the cells. Every command except
// purge gives one result. Purge first folds the pending count into top, then
// gives one store per valid slot (at most eight), or a single result when
// nothing is cached; the input is not ready during that scan. Results leave
// through one output register, so an accepted command needs that register free
// or being drained in the same cycle.
`include "fpu_stack_register_cache_assert.svh"

module fpu_stack_register_cache #(
	parameter int unsigned SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // st[2:0], top[5:3], zero[7:6]
	input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // slot[2:0], hit[3], full_res[4], action[6:5],
	                                   // phys_index[9:7], stack_delta[15:10],
	                                   // new_top[18:16], zero[23:19]
	output logic        m_axis_tlast
);
	import fpusrc_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);

	state_e            state_q, state_d;
	logic signed [5:0] pend_q, pend_d;
	logic [2:0]        cnt_q, cnt_d;
	logic signed [5:0] pdelta_q;
	logic [2:0]        ntop_q;
	logic              out_valid_q;
	res_t              out_q;
	logic              out_last_q;

	cmd_e       in_cmd;
	logic [2:0] in_st;
	logic [2:0] in_top;
	logic [2:0] sync_top;
	logic       accept_in;
	logic       out_free;

	cell_ctl_t  ctl;
	chain_t     chain [SLOTS+1];
	cell_stat_t stat  [SLOTS];

	logic [SLOTS-1:0] ff_vec, fh_vec, fv_vec;
	logic [3:0]       fv_depth;
	logic [2:0]       ff_slot, fh_slot, fv_slot;

	res_t res_d;
	logic emit;
	logic last_d;

	function automatic logic [2:0] slot_of(input logic [SLOTS-1:0] onehot);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < SLOTS; i++)
			if (onehot[i])
				idx = idx | IDX_W'(i);
		return 3'(idx);
	endfunction

	assign in_cmd    = cmd_e'(s_axis_tuser);
	assign in_st     = s_axis_tdata[2:0];
	assign in_top    = s_axis_tdata[5:3];
	assign sync_top  = in_top - pend_q[2:0];
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept_in = s_axis_tvalid && s_axis_tready;

	assign chain[0] = '0;

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		fpusrc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.st        (in_st),
			.chain_in  (chain[g]),
			.chain_out (chain[g+1]),
			.stat      (stat[g])
		);
		assign ff_vec[g] = stat[g].first_free;
		assign fh_vec[g] = stat[g].first_hit;
		assign fv_vec[g] = stat[g].first_valid;
	end

	always_comb begin
		fv_depth = '0;
		for (int i = 0; i < SLOTS; i++)
			if (fv_vec[i])
				fv_depth = fv_depth | stat[i].depth;
	end

	assign ff_slot = slot_of(ff_vec);
	assign fh_slot = slot_of(fh_vec);
	assign fv_slot = slot_of(fv_vec);

	always_comb begin
		state_d     = state_q;
		pend_d      = pend_q;
		cnt_d       = cnt_q;
		ctl.op      = OP_NONE;
		ctl.alloc   = !chain[SLOTS].hit_seen;
		res_d       = '0;
		res_d.new_top = in_top;
		emit        = 1'b0;
		last_d      = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					emit = 1'b1;
					case (in_cmd)
						CMD_RESET: begin
							ctl.op = OP_CLEAR;
							pend_d = '0;
						end
						CMD_PUSH: begin
							ctl.op = OP_PUSH;
							if (pend_q != PEND_MAX)
								pend_d = pend_q + 6'sd1;
							if (chain[SLOTS].free_seen)
								res_d.slot = ff_slot;
							else
								res_d.full_res = 1'b1;
						end
						CMD_POP: begin
							ctl.op = OP_POP;
							if (pend_q != PEND_MIN)
								pend_d = pend_q - 6'sd1;
						end
						CMD_GET: begin
							ctl.op = OP_GET;
							if (chain[SLOTS].hit_seen) begin
								res_d.slot = fh_slot;
								res_d.hit  = 1'b1;
							end else if (chain[SLOTS].free_seen) begin
								res_d.slot       = ff_slot;
								res_d.action     = ACT_LOAD;
								res_d.phys_index = sync_top + in_st;
							end else begin
								res_d.full_res = 1'b1;
							end
						end
						CMD_REFRESH: begin
							pend_d            = '0;
							res_d.new_top     = sync_top;
							res_d.stack_delta = pend_q;
							if (chain[SLOTS].hit_seen) begin
								res_d.slot       = fh_slot;
								res_d.action     = ACT_STORE;
								res_d.phys_index = sync_top + in_st;
							end
						end
						CMD_PURGE: begin
							// fold the pending count now, emit from the scan
							pend_d  = '0;
							cnt_d   = '0;
							emit    = 1'b0;
							state_d = ST_PURGE;
						end
						CMD_SYNC: begin
							pend_d            = '0;
							res_d.new_top     = sync_top;
							res_d.stack_delta = pend_q;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PURGE: begin
				res_d.new_top     = ntop_q;
				res_d.stack_delta = pdelta_q;
				if (out_free) begin
					emit = 1'b1;
					if (chain[SLOTS].valid_seen) begin
						ctl.op           = OP_FREE;
						res_d.slot       = fv_slot;
						res_d.action     = ACT_STORE;
						res_d.phys_index = ntop_q + fv_depth[2:0];
						last_d = !chain[SLOTS].valid_two || (cnt_q == PURGE_LAST_IX);
						cnt_d  = cnt_q + 3'd1;
					end
					if (last_d)
						state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
		end
	end

	// hold the folded delta and top for the whole purge scan
	always_ff @(posedge clk) begin
		if (accept_in && in_cmd == CMD_PURGE) begin
			pdelta_q <= pend_q;
			ntop_q   <= sync_top;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q      <= res_d;
			out_last_q <= last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tlast  = out_last_q;

	`FSRC_ASSERT_IMPL(a_no_req_in_purge, state_q == ST_PURGE, !s_axis_tready, "request accepted during purge scan")
	`FSRC_ASSERT(a_free_onehot, $onehot0(ff_vec) && $onehot0(fh_vec) && $onehot0(fv_vec), "priority chain selected more than one cell")
	`FSRC_ASSERT(a_reset_clears, (accept_in && in_cmd == CMD_RESET) |=> (pend_q == '0 && !chain[SLOTS].valid_seen), "reset command left state behind")
	`FSRC_ASSERT(a_purge_ends, (state_q == ST_PURGE && emit && last_d) |=> (state_q == ST_IDLE && out_last_q), "purge did not finish on its last result")

endmodule

// ===== rtl/fpusrc_cell.sv =====
// One slot of the register cache: valid flag, depth and priority chain stage.
module fpusrc_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fpusrc_pkg::cell_ctl_t  ctl,
	input  logic [2:0]             st,
	input  fpusrc_pkg::chain_t     chain_in,
	output fpusrc_pkg::chain_t     chain_out,
	output fpusrc_pkg::cell_stat_t stat
);
	import fpusrc_pkg::*;

	logic       valid_q;
	logic [3:0] depth_q;
	logic       match;
	logic       first_free;
	logic       first_hit;
	logic       first_valid;

	assign match       = valid_q && (depth_q == {1'b0, st});
	assign first_free  = !valid_q && !chain_in.free_seen;
	assign first_hit   = match && !chain_in.hit_seen;
	assign first_valid = valid_q && !chain_in.valid_seen;

	assign chain_out.free_seen  = chain_in.free_seen || !valid_q;
	assign chain_out.hit_seen   = chain_in.hit_seen || match;
	assign chain_out.valid_seen = chain_in.valid_seen || valid_q;
	assign chain_out.valid_two  = chain_in.valid_two || (valid_q && chain_in.valid_seen);

	assign stat.first_free  = first_free;
	assign stat.first_hit   = first_hit;
	assign stat.first_valid = first_valid;
	assign stat.depth       = depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			depth_q <= '0;
		end else begin
			case (ctl.op)
				OP_CLEAR: begin
					valid_q <= 1'b0;
					depth_q <= '0;
				end
				OP_PUSH: begin
					if (valid_q) begin
						if (depth_q != DEPTH_MAX)
							depth_q <= depth_q + 4'd1;
					end else if (first_free) begin
						valid_q <= 1'b1;
						depth_q <= '0;
					end
				end
				OP_POP: begin
					if (valid_q) begin
						if (depth_q == '0)
							valid_q <= 1'b0;
						else
							depth_q <= depth_q - 4'd1;
					end
				end
				OP_GET: begin
					if (ctl.alloc && first_free) begin
						valid_q <= 1'b1;
						depth_q <= {1'b0, st};
					end
				end
				OP_FREE: begin
					if (first_valid) begin
						valid_q <= 1'b0;
						depth_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
